/* src/block_byte_entropy_assert.svh */
// Assertion macros for the byte entropy block.
// Depends on nothing; included by the top level before its assertions.
`ifndef BLOCK_BYTE_ENTROPY_ASSERT_SVH
`define BLOCK_BYTE_ENTROPY_ASSERT_SVH

`ifndef SYNTHESIS
`define BBE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define BBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define BBE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* src/bbe_pkg.sv */
// Package for the byte entropy block: sizes, fixed point log2 and the c*log2(c) table.
// Depends on nothing; used by the interfaces and the top level.
package bbe_pkg;

  // Block length in bytes; must be a power of two so the final divide is a shift.
  localparam int BLOCK_BYTES = 32;
  localparam int BINS        = 256;
  localparam int BYTE_W      = 8;
  localparam int FRAC_W      = 16;
  localparam int INDEX_W     = 32;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);

  // log2(c) with 16 fraction bits, by repeated squaring of the mantissa.
  function automatic logic [31:0] log2q(input int unsigned c);
    int unsigned k;
    int          i;
    logic [31:0] frac;
    logic [63:0] m;
    k    = 0;
    frac = '0;
    if (c <= 1) begin
      return '0;
    end
    for (i = 1; i < 32; i++) begin
      if ((c >> i) != 0) begin
        k = i;
      end
    end
    m = 64'(c) << (30 - k);
    for (i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        frac[0] = 1'b1;
        m       = m >> 1;
      end
    end
    return 32'(k << 16) | frac;
  endfunction

  localparam int unsigned SUM_MAX     = BLOCK_BYTES * log2q(BLOCK_BYTES);
  localparam int          SUM_W       = $clog2(SUM_MAX + 1);
  localparam int          ROUND_SHIFT = $clog2(8 * BLOCK_BYTES);
  localparam int          ROUND_BIAS  = 4 * BLOCK_BYTES;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef sum_t clogc_rom_t [0:BLOCK_BYTES];

  function automatic clogc_rom_t build_clogc_rom();
    clogc_rom_t  rom;
    int unsigned c;
    for (c = 0; c <= BLOCK_BYTES; c++) begin
      rom[c] = SUM_W'(c * log2q(c));
    end
    return rom;
  endfunction

  // c*log2(c) for c = 0..BLOCK_BYTES, 16 fraction bits.
  localparam clogc_rom_t CLOGC_ROM = build_clogc_rom();

endpackage

/* src/bbe_in_if.sv */
// Input channel of the byte entropy block: one dump byte per transaction.
// Depends on bbe_pkg.
interface bbe_in_if;
  logic                        valid;
  logic                        ready;
  logic [bbe_pkg::BYTE_W-1:0]  data_byte;
  logic                        end_of_dump;

  modport source (output valid, output data_byte, output end_of_dump, input ready);
  modport sink   (input valid, input data_byte, input end_of_dump, output ready);
endinterface

/* src/bbe_out_if.sv */
// Output channel of the byte entropy block: one block result per transaction.
// Depends on bbe_pkg.
interface bbe_out_if;
  logic                        valid;
  logic                        ready;
  logic [bbe_pkg::FRAC_W-1:0]  entropy_frac;
  logic [bbe_pkg::INDEX_W-1:0] block_index;

  modport source (output valid, output entropy_frac, output block_index, input ready);
  modport sink   (input valid, input entropy_frac, input block_index, output ready);
endinterface

/* src/bbe_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing. Read during write at the same address returns old data.
module bbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/block_byte_entropy.sv */
// Byte entropy top level: 32-byte block histogram and base-256 entropy per block.
// Result: the result register loads when the block's last byte leaves stage 1.
// Throughput: one byte per cycle; a block's last byte stalls only while a result waits.
// Reset: async active low clears position, sum, block counter, histogram valid flags
// and handshake state; no clearing pass, the block takes bytes right after reset.
// Depends on bbe_pkg, bbe_in_if, bbe_out_if, bbe_ram and block_byte_entropy_assert.svh.
`include "block_byte_entropy_assert.svh"

module block_byte_entropy (
  input  logic  clk_i,
  input  logic  rst_ni,
  bbe_in_if.sink    in_i,
  bbe_out_if.source out_o
);

  localparam int RND_W = bbe_pkg::SUM_W + 1;

  // stage 1: accepted byte, histogram read in flight
  logic                             s1_valid_q;
  logic [bbe_pkg::BYTE_W-1:0]       s1_byte_q;
  logic                             s1_last_q;

  // block state
  logic [bbe_pkg::POS_W-1:0]        pos_q;
  bbe_pkg::sum_t                    sum_q;
  bbe_pkg::cnt_t                    zero_cnt_q;
  logic [bbe_pkg::INDEX_W-1:0]      blk_cnt_q;
  logic [bbe_pkg::BINS-1:0]         hist_valid_q;

  // last histogram write, covers read during write
  logic                             byp_valid_q;
  logic [bbe_pkg::BYTE_W-1:0]       byp_addr_q;
  bbe_pkg::cnt_t                    byp_data_q;

  // result register
  logic                             out_valid_q;
  logic [bbe_pkg::FRAC_W-1:0]       out_frac_q;
  logic [bbe_pkg::INDEX_W-1:0]      out_index_q;
  logic [bbe_pkg::FRAC_W-1:0]       out_frac_d;

  logic                             in_accept;
  logic                             out_free;
  logic                             s1_emit;
  logic                             s1_fire;
  logic                             byp_hit;
  bbe_pkg::cnt_t                    ram_rdata;
  bbe_pkg::cnt_t                    cnt_cur;
  bbe_pkg::cnt_t                    cnt_inc;
  bbe_pkg::cnt_t                    zero_after;
  bbe_pkg::cnt_t                    pad;
  bbe_pkg::cnt_t                    zero_pad;
  bbe_pkg::sum_t                    sum_step;
  bbe_pkg::sum_t                    sum_final;
  logic [RND_W-1:0]                 n_diff;
  logic [RND_W-1:0]                 n_round;
  logic [RND_W-bbe_pkg::ROUND_SHIFT-1:0] frac_full;

  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_emit   = s1_last_q || (pos_q == bbe_pkg::POS_W'(bbe_pkg::BLOCK_BYTES - 1));
  assign s1_fire   = s1_valid_q && (!s1_emit || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_accept = in_i.valid && in_i.ready;

  bbe_ram #(
    .WIDTH (bbe_pkg::CNT_W),
    .DEPTH (bbe_pkg::BINS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire && !s1_emit),
    .waddr_i (s1_byte_q),
    .wdata_i (cnt_inc),
    .re_i    (in_accept),
    .raddr_i (in_i.data_byte),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    byp_hit = byp_valid_q && (byp_addr_q == s1_byte_q);
    if (byp_hit) begin
      cnt_cur = byp_data_q;
    end else if (hist_valid_q[s1_byte_q]) begin
      cnt_cur = ram_rdata;
    end else begin
      cnt_cur = '0;
    end
    cnt_inc  = cnt_cur + bbe_pkg::CNT_W'(1);
    sum_step = sum_q + (bbe_pkg::CLOGC_ROM[cnt_inc] - bbe_pkg::CLOGC_ROM[cnt_cur]);

    // missing bytes of a short block go to bin 0; pad is zero on a full block
    zero_after = (s1_byte_q == '0) ? cnt_inc : zero_cnt_q;
    pad        = bbe_pkg::CNT_W'(bbe_pkg::BLOCK_BYTES - 1) - bbe_pkg::CNT_W'(pos_q);
    zero_pad   = zero_after + pad;
    sum_final  = sum_step
               + (bbe_pkg::CLOGC_ROM[zero_pad] - bbe_pkg::CLOGC_ROM[zero_after]);

    n_diff = RND_W'(bbe_pkg::SUM_MAX) - {1'b0, sum_final};
    if (n_diff[RND_W-1]) begin
      n_diff = '0;
    end
    n_round   = n_diff + RND_W'(bbe_pkg::ROUND_BIAS);
    frac_full = n_round[RND_W-1:bbe_pkg::ROUND_SHIFT];
    if (frac_full > (RND_W-bbe_pkg::ROUND_SHIFT)'({bbe_pkg::FRAC_W{1'b1}})) begin
      out_frac_d = '1;
    end else begin
      out_frac_d = frac_full[bbe_pkg::FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      pos_q        <= '0;
      sum_q        <= '0;
      zero_cnt_q   <= '0;
      blk_cnt_q    <= '0;
      hist_valid_q <= '0;
      byp_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_fire) begin
        if (s1_emit) begin
          pos_q        <= '0;
          sum_q        <= '0;
          zero_cnt_q   <= '0;
          hist_valid_q <= '0;
          byp_valid_q  <= 1'b0;
          blk_cnt_q    <= blk_cnt_q + bbe_pkg::INDEX_W'(1);
        end else begin
          pos_q                   <= pos_q + bbe_pkg::POS_W'(1);
          sum_q                   <= sum_step;
          zero_cnt_q              <= zero_after;
          hist_valid_q[s1_byte_q] <= 1'b1;
          byp_valid_q             <= 1'b1;
        end
      end
      if (s1_fire && s1_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.end_of_dump;
    end
    if (s1_fire && !s1_emit) begin
      byp_addr_q <= s1_byte_q;
      byp_data_q <= cnt_inc;
    end
    if (s1_fire && s1_emit) begin
      out_frac_q  <= out_frac_d;
      out_index_q <= blk_cnt_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.entropy_frac = out_frac_q;
  assign out_o.block_index  = out_index_q;

  `BBE_ASSERT_NEXT(a_block_clear, clk_i, rst_ni, s1_fire && s1_emit,
                   pos_q == '0 && hist_valid_q == '0 && !byp_valid_q)
  `BBE_ASSERT_NEXT(a_result_index, clk_i, rst_ni, s1_fire && s1_emit,
                   out_valid_q && out_index_q == $past(blk_cnt_q))
  `BBE_ASSERT_IMPL(a_zero_bound, clk_i, rst_ni, 1'b1,
                   zero_cnt_q <= bbe_pkg::CNT_W'(pos_q))
  `BBE_ASSERT_IMPL(a_bypass_flag, clk_i, rst_ni, byp_valid_q, hist_valid_q[byp_addr_q])

endmodule
